>>> rtl/csu_pkg.sv
`default_nettype none

package csu_pkg;

    localparam int NUM_THREADS_DEF = 32;
    localparam int REQ_W           = 2;
    localparam int TID_W           = 5;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 8;

    localparam logic [REQ_W-1:0] REQ_WAIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GIVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TRY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_COUNT_RST = 8'd1;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [TID_W-1:0] thread_id;
    } csu_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wake_valid;
        logic [TID_W-1:0]    woken_id;
    } csu_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load_cfg;
    } csu_cmd_t;

endpackage

`default_nettype wire

>>> rtl/counting_semaphore_unit_top.sv
`default_nettype none

// channel  | signals                         | direction
// ---------+---------------------------------+----------
// request  | in_valid, in_stall, in_data     | in
// response | out_valid, out_stall, out_data  | out
// config   | cfg_we, cfg_data (limit)        | in
//
// one item per cycle while in_stall is low; the result enters the output register
// as the item is taken, count, mask and lowest-waiter encode being combinational
// reset: limit and count 1, no waiters, output empty
// in_stall rises only while a result is held and out_stall is high

module counting_semaphore_unit_top #(
    parameter int NUM_THREADS = csu_pkg::NUM_THREADS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire csu_pkg::csu_req_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output csu_pkg::csu_rsp_t                out_data,
    input  wire logic                        cfg_we,
    input  wire logic [csu_pkg::COUNT_W-1:0] cfg_data
);
    import csu_pkg::*;

    csu_cmd_t cmd;

    csu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cmd       (cmd)
    );

    csu_dp #(
        .NUM_THREADS (NUM_THREADS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (in_data),
        .cfg_data (cfg_data),
        .rsp      (out_data)
    );

`ifndef ASSERT_OFF
    a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result held");

    a_wake_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.wake_valid) |-> (out_data.status == ST_DONE))
        else $error("wake with non-done status");

    a_no_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.wake_valid) |-> (out_data.woken_id == '0))
        else $error("woken_id set without wake");

    a_try_never_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.req_type == REQ_TRY)
        |=> (out_data.status != ST_BLOCKED))
        else $error("try-wait blocked");
`endif

endmodule

`default_nettype wire

>>> rtl/csu_ctrl.sv
`default_nettype none

module csu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire logic             cfg_we,
    output csu_pkg::csu_cmd_t     cmd
);
    import csu_pkg::*;

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_FULL  = 1'b1;

    logic state_reg;
    logic state_next;

    // a new item may enter whenever the result register is free or draining
    assign in_stall     = (state_reg == S_FULL) && out_stall;
    assign out_valid    = (state_reg == S_FULL);
    assign cmd.exec     = in_valid && !in_stall;
    assign cmd.load_cfg = cfg_we;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_EMPTY:
            begin
                if (cmd.exec)
                begin
                    state_next = S_FULL;
                end
            end
            S_FULL:
            begin
                if (!out_stall && !cmd.exec)
                begin
                    state_next = S_EMPTY;
                end
            end
            default:
            begin
                state_next = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/csu_dp.sv
`default_nettype none

module csu_dp #(
    parameter int NUM_THREADS = csu_pkg::NUM_THREADS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csu_pkg::csu_cmd_t             cmd,
    input  wire csu_pkg::csu_req_t             req,
    input  wire logic [csu_pkg::COUNT_W-1:0]   cfg_data,
    output csu_pkg::csu_rsp_t                  rsp
);
    import csu_pkg::*;

    localparam int IDX_W = $clog2(NUM_THREADS);

    logic [COUNT_W-1:0]     max_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [NUM_THREADS-1:0] mask_reg;
    logic [NUM_THREADS-1:0] mask_next;
    logic [NUM_THREADS-1:0] tid_bit;
    logic [NUM_THREADS-1:0] low_bit;
    logic [IDX_W-1:0]       low_idx;
    logic [IDX_W+TID_W-1:0] low_idx_wide;
    logic                   tid_in_range;
    csu_rsp_t               rsp_reg;
    csu_rsp_t               rsp_next;

    assign tid_bit      = {{(NUM_THREADS-1){1'b0}}, 1'b1} << req.thread_id;
    assign tid_in_range = 32'(req.thread_id) < NUM_THREADS;

    // lowest waiting thread
    always_comb
    begin
        low_idx = '0;
        for (int i = NUM_THREADS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign low_bit      = {{(NUM_THREADS-1){1'b0}}, 1'b1} << low_idx;
    assign low_idx_wide = {{TID_W{1'b0}}, low_idx};

    always_comb
    begin
        count_next          = count_reg;
        mask_next           = mask_reg;
        rsp_next.status     = ST_DONE;
        rsp_next.wake_valid = 1'b0;
        rsp_next.woken_id   = '0;
        case (req.req_type)
            REQ_WAIT, REQ_TRY:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                else if (req.req_type == REQ_TRY || !tid_in_range)
                begin
                    rsp_next.status = ST_REFUSED;
                end
                else
                begin
                    mask_next       = mask_reg | tid_bit;
                    rsp_next.status = ST_BLOCKED;
                end
            end
            REQ_GIVE:
            begin
                if (mask_reg != '0)
                begin
                    mask_next           = mask_reg & ~low_bit;
                    rsp_next.wake_valid = 1'b1;
                    rsp_next.woken_id   = low_idx_wide[TID_W-1:0];
                end
                else if (count_reg < max_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                // unknown request: no change, answers done
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= MAX_COUNT_RST;
            count_reg <= MAX_COUNT_RST;
            mask_reg  <= '0;
        end
        else if (cmd.load_cfg)
        begin
            // zero maximum is ignored
            if (cfg_data != '0)
            begin
                max_reg   <= cfg_data;
                count_reg <= cfg_data;
                mask_reg  <= '0;
            end
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

>>> test/counting_semaphore_unit_top_tb.sv
`default_nettype none

module counting_semaphore_unit_top_tb;

    import csu_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int LIMIT_CYCLES   = 600000;
    localparam int RAND_PER_PHASE = 204;
    localparam int NUM_PHASES     = 9;
    localparam int DIR_ROWS       = 25;
    localparam int HOLD_CYCLES    = 80;

    // request code with no meaning, must leave the state alone
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam bit ROW_REQ = 1'b0;
    localparam bit ROW_CFG = 1'b1;
    localparam bit PRED    = 1'b0;
    localparam bit TYPED   = 1'b1;

    typedef struct packed {
        bit                 is_cfg;
        logic [REQ_W-1:0]   rtype;
        logic [TID_W-1:0]   tid;
        logic [COUNT_W-1:0] cval;
        bit                 typed;
        csu_rsp_t           rsp;
    } dir_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    csu_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    csu_rsp_t out_data;
    logic cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    // semaphore state as the block should hold it
    logic [COUNT_W-1:0] max_reg = MAX_COUNT_RST;
    logic [COUNT_W-1:0] sem_count = MAX_COUNT_RST;
    logic [31:0] wait_mask = '0;

    csu_rsp_t exp_q[$];

    bit calm = 1'b0;
    int rx_hold = 0;
    int rx_wait = 0;
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_blocked = 0;
    int n_wakes = 0;
    int n_refused = 0;
    int n_cfg = 0;

    logic [COUNT_W-1:0] phase_max [NUM_PHASES] =
        '{8'd1, 8'd2, 8'd4, 8'd255, 8'd0, 8'd7, 8'd1, 8'd1, 8'd3};

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_REQ, REQ_WAIT,    5'd0,  8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_TRY,     5'd3,  8'd0,   TYPED, '{ST_REFUSED, 1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd5,  8'd0,   TYPED, '{ST_BLOCKED, 1'b0, 5'd0}},
        // same thread waits again
        '{ROW_REQ, REQ_WAIT,    5'd5,  8'd0,   TYPED, '{ST_BLOCKED, 1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd31, 8'd0,   TYPED, '{ST_BLOCKED, 1'b0, 5'd0}},
        '{ROW_REQ, REQ_GIVE,    5'd0,  8'd0,   TYPED, '{ST_DONE,    1'b1, 5'd5}},
        '{ROW_REQ, REQ_GIVE,    5'd1,  8'd0,   TYPED, '{ST_DONE,    1'b1, 5'd31}},
        '{ROW_REQ, REQ_GIVE,    5'd2,  8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        // give with the count already at max
        '{ROW_REQ, REQ_GIVE,    5'd2,  8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_UNKNOWN, 5'd31, 8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        // zero max is dropped, count stays 1
        '{ROW_CFG, REQ_WAIT,    5'd0,  8'd0,   PRED,  '0},
        '{ROW_REQ, REQ_TRY,     5'd0,  8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_TRY,     5'd1,  8'd0,   TYPED, '{ST_REFUSED, 1'b0, 5'd0}},
        '{ROW_CFG, REQ_WAIT,    5'd0,  8'd255, PRED,  '0},
        '{ROW_REQ, REQ_GIVE,    5'd31, 8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd31, 8'd0,   PRED,  '0},
        '{ROW_REQ, REQ_TRY,     5'd16, 8'd0,   PRED,  '0},
        '{ROW_CFG, REQ_WAIT,    5'd0,  8'd1,   PRED,  '0},
        '{ROW_REQ, REQ_WAIT,    5'd10, 8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd20, 8'd0,   TYPED, '{ST_BLOCKED, 1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd10, 8'd0,   TYPED, '{ST_BLOCKED, 1'b0, 5'd0}},
        // reload drops both waiters
        '{ROW_CFG, REQ_WAIT,    5'd0,  8'd3,   PRED,  '0},
        '{ROW_REQ, REQ_GIVE,    5'd0,  8'd0,   TYPED, '{ST_DONE,    1'b0, 5'd0}},
        '{ROW_REQ, REQ_WAIT,    5'd21, 8'd0,   PRED,  '0},
        '{ROW_REQ, REQ_UNKNOWN, 5'd0,  8'd0,   PRED,  '0}
    };

    counting_semaphore_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    function automatic csu_rsp_t sem_step(csu_req_t r);
        csu_rsp_t o;
        o = '0;
        o.status = ST_DONE;
        if (r.req_type == REQ_WAIT || r.req_type == REQ_TRY)
        begin
            if (sem_count != 0)
                sem_count = sem_count - 1'b1;
            else if (r.req_type == REQ_TRY)
                o.status = ST_REFUSED;
            else
            begin
                wait_mask[r.thread_id] = 1'b1;
                o.status = ST_BLOCKED;
            end
        end
        else if (r.req_type == REQ_GIVE)
        begin
            if (wait_mask != 0)
            begin
                // lowest waiting thread wins
                for (int i = 31; i >= 0; i--)
                    if (wait_mask[i])
                        o.woken_id = i[TID_W-1:0];
                wait_mask[o.woken_id] = 1'b0;
                o.wake_valid = 1'b1;
            end
            else if (sem_count < max_reg)
                sem_count = sem_count + 1'b1;
        end
        return o;
    endfunction

    // entered after a rising edge, returns at the edge that takes the item
    task automatic send_item(csu_req_t r, bit typed, csu_rsp_t typed_rsp);
        int gap;
        csu_rsp_t p;
        gap = calm ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = sem_step(r);
        exp_q.push_back(typed ? typed_rsp : p);
        n_items++;
    endtask

    // only with nothing in flight
    task automatic set_max(logic [COUNT_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (v != 0)
        begin
            max_reg = v;
            sem_count = v;
            wait_mask = '0;
        end
        n_cfg++;
    endtask

    // receiver: long hold-off first, then the per-item wait
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : rsp_check
        csu_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            rx_wait = calm ? 0 : $urandom_range(0, 11);
            if (exp_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d wake %0d thread %0d",
                             out_data.status, out_data.wake_valid, out_data.woken_id);
            end
            else
            begin
                want = exp_q.pop_front();
                if (want.status == ST_BLOCKED)
                    n_blocked++;
                if (want.status == ST_REFUSED)
                    n_refused++;
                if (want.wake_valid)
                    n_wakes++;
                if (out_data.status !== want.status
                    || out_data.wake_valid !== want.wake_valid
                    || out_data.woken_id !== want.woken_id)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected status %0d wake %0d thread %0d,",
                                  " got status %0d wake %0d thread %0d"},
                                 want.status, want.wake_valid, want.woken_id,
                                 out_data.status, out_data.wake_valid, out_data.woken_id);
                end
            end
        end
    end

    initial
    begin
        int k;
        int ph;
        int j;
        int roll;
        int give_pct;
        int spin;
        csu_req_t rq;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tab[k].is_cfg)
                set_max(dir_tab[k].cval);
            else
            begin
                rq.req_type = dir_tab[k].rtype;
                rq.thread_id = dir_tab[k].tid;
                send_item(rq, dir_tab[k].typed, dir_tab[k].rsp);
            end
        end

        phase_max[6] = COUNT_W'($urandom_range(1, 255));
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_max(phase_max[ph]);
            calm = (ph == 2 || ph == 5);
            // output blocked for a while, sender keeps pushing back to back
            if (ph == 5)
                rx_hold = HOLD_CYCLES;
            give_pct = (phase_max[ph] == 8'd255) ? 5 : 30;
            for (j = 0; j < RAND_PER_PHASE; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    rq.req_type = REQ_WAIT;
                else if (roll < 40 + give_pct)
                    rq.req_type = REQ_GIVE;
                else if (roll < 95)
                    rq.req_type = REQ_TRY;
                else
                    rq.req_type = REQ_UNKNOWN;
                rq.thread_id = TID_W'($urandom_range(0, 31));
                send_item(rq, PRED, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        spin = 0;
        while (exp_q.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (4) @(posedge clk);
        if (exp_q.size() != 0)
        begin
            errors += exp_q.size();
            $display("%0d results never arrived", exp_q.size());
        end

        $display("run covered %0d requests and %0d limit writes, %0d results checked",
                 n_items, n_cfg, n_results);
        $display("of which %0d blocked waits, %0d wakes, %0d refusals; %0d mismatches",
                 n_blocked, n_wakes, n_refused, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/csu_pkg.sv
rtl/csu_ctrl.sv
rtl/csu_dp.sv
rtl/counting_semaphore_unit_top.sv
test/counting_semaphore_unit_top_tb.sv
